[hdl/xbm_pkg.sv]
// ----------------------------------------------------------------------------
// xbm_pkg
// Shared types and constants for the bitmap blit block: register indexes,
// colour codes, default widths and the per-byte job record.
// ----------------------------------------------------------------------------
`default_nettype none

package xbm_pkg;

  // Default coordinate width and configuration port geometry.
  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned CfgDataW         = 16;
  localparam int unsigned CfgIdxW          = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegOriginX   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWidth     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeight    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMode      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTransp    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDrawColor = 3'd6;

  // Pixel colour codes.
  localparam logic [1:0] ColorClear = 2'd0;
  localparam logic [1:0] ColorSet   = 2'd1;
  localparam logic [1:0] ColorXor   = 2'd2;

  // Orientation mode codes.
  localparam logic [1:0] ModeNone     = 2'd0;
  localparam logic [1:0] ModeRotate   = 2'd1;
  localparam logic [1:0] ModeMirror   = 2'd2;
  localparam logic [1:0] ModeMirRot   = 2'd3;

  // One accepted byte, ready for expansion into pixel writes.
  typedef struct packed {
    logic [7:0] emit_mask;  // pixels of this byte that produce a write
    logic [7:0] bits;       // source bits, select between the two colours
    logic [1:0] color;      // colour for set bits
    logic [1:0] ncolor;     // colour for clear bits
    logic       rotate;     // pixels advance along y instead of x
    logic       done;       // this byte completes the bitmap
  } job_t;

endpackage : xbm_pkg

`default_nettype wire

[hdl/xbm_pix_ser.sv]
// ----------------------------------------------------------------------------
// xbm_pix_ser
// Pixel serializer: holds one byte job and walks its emitting pixels into an
// output register, one pixel write per cycle unless pixel_ready_i stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module xbm_pix_ser #(
  parameter int unsigned COORD_BITS = xbm_pkg::CoordBitsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Job input.
  input  wire logic                  job_valid_i,
  output logic                       job_ready_o,
  input  wire xbm_pkg::job_t         job_i,
  input  wire logic [COORD_BITS-1:0] job_x_i,
  input  wire logic [COORD_BITS-1:0] job_y_i,
  // Pixel output.
  output logic                       pixel_valid_o,
  input  wire logic                  pixel_ready_i,
  output logic [COORD_BITS-1:0]      pixel_x_o,
  output logic [COORD_BITS-1:0]      pixel_y_o,
  output logic [1:0]                 pixel_color_o,
  output logic                       run_last_o,
  output logic                       blit_done_o
);
  import xbm_pkg::*;

  job_t                  job_q;
  logic                  job_v_q;
  logic [COORD_BITS-1:0] base_x_q, base_y_q;

  logic                  out_v_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [1:0]            pc_q;
  logic                  last_q, done_q;

  logic                  out_load;
  logic [2:0]            sel;
  logic [7:0]            rest_mask;
  logic                  job_last;
  logic [COORD_BITS-1:0] nx, ny;

  // The output register can take a pixel when empty or being drained.
  assign out_load = !out_v_q || pixel_ready_i;

  // Lowest pending pixel of the job.
  always_comb begin
    sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (job_q.emit_mask[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign rest_mask = job_q.emit_mask & (job_q.emit_mask - 8'd1);
  assign job_last  = (rest_mask == 8'd0);

  // Pixel coordinate: step along the advance axis by the pixel position.
  always_comb begin
    nx = base_x_q;
    ny = base_y_q;
    if (job_q.rotate) begin
      ny = base_y_q + COORD_BITS'(sel);
    end else begin
      nx = base_x_q + COORD_BITS'(sel);
    end
  end

  // A new job enters when the slot is empty or its last pixel leaves now.
  assign job_ready_o = !job_v_q || (out_load && job_last);

  // Job slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
    end else if (job_valid_i && job_ready_o) begin
      job_v_q <= 1'b1;
    end else if (job_v_q && out_load && job_last) begin
      job_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q    <= job_i;
      base_x_q <= job_x_i;
      base_y_q <= job_y_i;
    end else if (job_v_q && out_load) begin
      job_q.emit_mask <= rest_mask;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= job_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && job_v_q) begin
      px_q   <= nx;
      py_q   <= ny;
      pc_q   <= job_q.bits[sel] ? job_q.color : job_q.ncolor;
      last_q <= job_last;
      done_q <= job_last && job_q.done;
    end
  end

  assign pixel_valid_o = out_v_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign run_last_o    = last_q;
  assign blit_done_o   = done_q;

endmodule : xbm_pix_ser

`default_nettype wire

[hdl/xbm_bitmap_blit_rotate.sv]
// Each accepted byte is held in the serializer's job slot, and its pixel writes
// leave through the serializer's output register, lowest pixel first.
// Throughput: one pixel write per cycle while pixel_ready_i is high, set by the
// single output register of the serializer; a byte emits 0 to 8 pixels.
// Bytes that emit nothing bypass the job slot. Reset clears the configuration to
// its defaults (draw colour set) and ends any blit in progress.
// ----------------------------------------------------------------------------
// xbm_bitmap_blit_rotate
// Expands 1-bit-per-pixel bitmap bytes into pixel writes with one of four
// orientations; row and cursor tracking is updated as each byte is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module xbm_bitmap_blit_rotate #(
  parameter int unsigned COORD_BITS = xbm_pkg::CoordBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [xbm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [xbm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Bitmap byte input.
  input  wire logic                          data_valid_i,
  output logic                               data_ready_o,
  input  wire logic [7:0]                    data_byte_i,
  // Pixel write output.
  output logic                               pixel_valid_o,
  input  wire logic                          pixel_ready_i,
  output logic [COORD_BITS-1:0]              pixel_x_o,
  output logic [COORD_BITS-1:0]              pixel_y_o,
  output logic [1:0]                         pixel_color_o,
  output logic                               run_last_o,
  output logic                               blit_done_o
);
  import xbm_pkg::*;

  // Configuration registers.
  logic [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic [7:0]            width_q, height_q;
  logic [1:0]            mode_q, draw_color_q;
  logic                  transp_q;

  // Blit tracking state.
  logic                  active_q;
  logic [7:0]            col_q, rows_q;
  logic [COORD_BITS-1:0] rsx_q, rsy_q, cx_q, cy_q;

  logic                  rotate, accept, blit_ok;
  logic [COORD_BITS-1:0] start_x, start_y;
  logic [COORD_BITS-1:0] eff_rsx, eff_rsy, eff_cx, eff_cy;
  logic [7:0]            eff_col, eff_rows, rem, sum_col, rows_dec;
  logic [3:0]            npix;
  logic [7:0]            pix_mask, emit_mask;
  logic                  row_end;
  logic [COORD_BITS-1:0] step_rsx, step_rsy, adv_cx, adv_cy;
  logic [1:0]            color, ncolor;
  job_t                  job;
  logic                  job_valid, job_ready;

  assign rotate  = mode_q[0];
  assign blit_ok = (width_q != 8'd0) && (height_q != 8'd0);
  assign accept  = data_valid_i && data_ready_o;

  // Row start of a fresh blit, including the orientation offset.
  always_comb begin
    start_x = origin_x_q;
    start_y = origin_y_q;
    if (mode_q == ModeRotate) begin
      start_x = origin_x_q + COORD_BITS'(width_q) + COORD_BITS'(1);
    end else if (mode_q == ModeMirror) begin
      start_y = origin_y_q + COORD_BITS'(height_q) - COORD_BITS'(1);
    end
  end

  // State seen by this byte: a fresh blit when none is active.
  assign eff_rsx  = active_q ? rsx_q  : start_x;
  assign eff_rsy  = active_q ? rsy_q  : start_y;
  assign eff_cx   = active_q ? cx_q   : start_x;
  assign eff_cy   = active_q ? cy_q   : start_y;
  assign eff_col  = active_q ? col_q  : 8'd0;
  assign eff_rows = active_q ? rows_q : height_q;

  // Pixels covered by this byte, padding bits dropped.
  assign rem  = width_q - eff_col;
  assign npix = (rem > 8'd8) ? 4'd8 : rem[3:0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pix_mask[i] = (4'(i) < npix);
    end
  end

  assign emit_mask = pix_mask & (transp_q ? data_byte_i : 8'hFF);
  assign sum_col   = eff_col + {4'd0, npix};
  assign row_end   = (sum_col == width_q);
  assign rows_dec  = eff_rows - 8'd1;

  // Cursor advance within a row and row start step at a row end.
  always_comb begin
    adv_cx   = eff_cx;
    adv_cy   = eff_cy;
    step_rsx = eff_rsx;
    step_rsy = eff_rsy;
    if (rotate) begin
      adv_cy = eff_cy + COORD_BITS'(npix);
    end else begin
      adv_cx = eff_cx + COORD_BITS'(npix);
    end
    unique case (mode_q)
      ModeNone:   step_rsy = eff_rsy + COORD_BITS'(1);
      ModeRotate: step_rsx = eff_rsx - COORD_BITS'(1);
      ModeMirror: step_rsy = eff_rsy - COORD_BITS'(1);
      ModeMirRot: step_rsx = eff_rsx + COORD_BITS'(1);
      default:    step_rsy = eff_rsy;
    endcase
  end

  // Colours: code three behaves as xor; clear bits take set for a clear draw colour, else clear.
  assign color  = (draw_color_q > ColorXor) ? ColorXor : draw_color_q;
  assign ncolor = (color == ColorClear) ? ColorSet : ColorClear;

  assign job.emit_mask = emit_mask;
  assign job.bits      = data_byte_i;
  assign job.color     = color;
  assign job.ncolor    = ncolor;
  assign job.rotate    = rotate;
  assign job.done      = row_end && (rows_dec == 8'd0);

  assign job_valid    = data_valid_i && blit_ok && (emit_mask != 8'd0);
  assign data_ready_o = job_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      width_q      <= 8'd0;
      height_q     <= 8'd0;
      mode_q       <= ModeNone;
      transp_q     <= 1'b0;
      draw_color_q <= ColorSet;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOriginX:   origin_x_q   <= cfg_wdata_i[COORD_BITS-1:0];
        RegOriginY:   origin_y_q   <= cfg_wdata_i[COORD_BITS-1:0];
        RegWidth:     width_q      <= cfg_wdata_i[7:0];
        RegHeight:    height_q     <= cfg_wdata_i[7:0];
        RegMode:      mode_q       <= cfg_wdata_i[1:0];
        RegTransp:    transp_q     <= cfg_wdata_i[0];
        RegDrawColor: draw_color_q <= cfg_wdata_i[1:0];
        default:      ;
      endcase
    end
  end

  // Blit tracking: updated once per accepted byte of a nonzero-size bitmap; a write to registers 0 to 6 aborts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      col_q    <= 8'd0;
      rows_q   <= 8'd0;
      rsx_q    <= '0;
      rsy_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i <= RegDrawColor) begin
        active_q <= 1'b0;
      end
    end else if (accept && blit_ok) begin
      if (row_end) begin
        rsx_q    <= step_rsx;
        rsy_q    <= step_rsy;
        cx_q     <= step_rsx;
        cy_q     <= step_rsy;
        col_q    <= 8'd0;
        rows_q   <= rows_dec;
        active_q <= (rows_dec != 8'd0);
      end else begin
        rsx_q    <= eff_rsx;
        rsy_q    <= eff_rsy;
        cx_q     <= adv_cx;
        cy_q     <= adv_cy;
        col_q    <= sum_col;
        rows_q   <= eff_rows;
        active_q <= 1'b1;
      end
    end
  end

  xbm_pix_ser #(
    .COORD_BITS (COORD_BITS)
  ) u_pix_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_ready_o   (job_ready),
    .job_i         (job),
    .job_x_i       (eff_cx),
    .job_y_i       (eff_cy),
    .pixel_valid_o (pixel_valid_o),
    .pixel_ready_i (pixel_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .run_last_o    (run_last_o),
    .blit_done_o   (blit_done_o)
  );

  // The end of a bitmap always closes a byte's run of pixels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o && blit_done_o |-> run_last_o)
    else $error("blit_done without run_last");

  // An active blit always has rows left to draw.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> rows_q != 8'd0)
    else $error("active blit with no rows left");

  // A one-row bitmap no wider than a byte finishes with its first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !active_q && !cfg_we_i && height_q == 8'd1 && width_q != 8'd0
      && width_q <= 8'd8 |=> !active_q)
    else $error("single-byte bitmap left the blit active");

endmodule : xbm_bitmap_blit_rotate

`default_nettype wire
